FILE: rtl/core/lbse_pkg.sv
package lbse_pkg;

    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned TRAILER_W     = 4;
    localparam logic [TRAILER_W-1:0] TRAILER_RESET = 4'd9;

    localparam logic [15:0] IDLE_PATTERN = 16'h4444;
    localparam logic [15:0] BIT3_MASK    = 16'h2000;
    localparam logic [15:0] BIT2_MASK    = 16'h0200;
    localparam logic [15:0] BIT1_MASK    = 16'h0020;
    localparam logic [15:0] BIT0_MASK    = 16'h0002;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } lbse_in_t;

    typedef struct packed {
        logic [15:0] spi_word;
        logic        last_word;
    } lbse_out_t;

    // classified byte held between front and back
    typedef struct packed {
        logic       lead;
        logic       last;
        logic [7:0] data;
    } lbse_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_HI,
        ST_LO,
        ST_TRAIL
    } lbse_state_t;

    function automatic logic [15:0] nibble_word(input logic [3:0] nib);
        logic [15:0] w;
        w = IDLE_PATTERN;
        if (nib[3]) w = w | BIT3_MASK;
        if (nib[2]) w = w | BIT2_MASK;
        if (nib[1]) w = w | BIT1_MASK;
        if (nib[0]) w = w | BIT0_MASK;
        return w;
    endfunction

endpackage

FILE: rtl/core/lbse_front.sv
module lbse_front
    import lbse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  lbse_in_t    in_item,
    output logic        push_valid,
    input  logic        push_full,
    output lbse_entry_t push_entry
);

    logic frame_start_reg;
    logic frame_start_next;
    logic accept;

    assign in_stall   = push_full;
    assign accept     = in_valid && !push_full;
    assign push_valid = accept;

    always_comb
    begin
        push_entry.lead = frame_start_reg;
        push_entry.last = in_item.last_byte;
        push_entry.data = in_item.data_byte;
    end

    always_comb
    begin
        frame_start_next = frame_start_reg;
        if (accept)
        begin
            frame_start_next = in_item.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= 1'b1;
        end
        else
        begin
            frame_start_reg <= frame_start_next;
        end
    end

    a_lead_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_item.last_byte |=> frame_start_reg)
        else $error("frame start not set after last byte");

    a_no_lead_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_item.last_byte |=> !frame_start_reg)
        else $error("frame start set inside a frame");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_full |-> !push_valid)
        else $error("push into full queue");

endmodule

FILE: rtl/core/lbse_queue.sv
module lbse_queue
    import lbse_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_full,
    input  lbse_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop_stall,
    output lbse_entry_t pop_entry
);

    localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CNT_W = $clog2(Depth + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Depth - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Depth);

    lbse_entry_t      slot_reg [Depth];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_full = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign push      = push_valid && !push_full;
    assign pop       = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_pop_only_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count wrong after pop");

    a_push_only_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count wrong after push");

endmodule

FILE: rtl/core/lbse_back.sv
module lbse_back
    import lbse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TRAILER_W-1:0] cfg_data,
    input  logic                 pop_valid,
    output logic                 pop_stall,
    input  lbse_entry_t          pop_entry,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lbse_out_t            out_item
);

    lbse_state_t          state_reg;
    lbse_state_t          state_next;
    lbse_entry_t          cur_reg;
    lbse_entry_t          cur_next;
    logic [TRAILER_W-1:0] cnt_reg;
    logic [TRAILER_W-1:0] cnt_next;
    logic [TRAILER_W-1:0] trailer_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lbse_out_t            out_item_reg;
    lbse_out_t            out_item_next;

    logic        advance;
    logic        finish;
    logic        load;
    logic        has_trailer;
    logic [15:0] word_data;
    logic        word_last;

    assign has_trailer = (trailer_reg != '0);
    assign advance     = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);
    assign load        = pop_valid && !pop_stall;
    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;

    // outputs of the sequencer
    always_comb
    begin
        word_data = '0;
        word_last = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                finish = 1'b0;
            end
            ST_LEAD:
            begin
                word_data = '0;
            end
            ST_HI:
            begin
                word_data = nibble_word(cur_reg.data[7:4]);
            end
            ST_LO:
            begin
                word_data = nibble_word(cur_reg.data[3:0]);
                word_last = cur_reg.last && !has_trailer;
                finish    = advance && !(cur_reg.last && has_trailer);
            end
            ST_TRAIL:
            begin
                word_last = (cnt_reg == TRAILER_W'(1));
                finish    = advance && (cnt_reg == TRAILER_W'(1));
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
        pop_stall = !((state_reg == ST_IDLE) || finish);
    end

    // next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_LEAD:
            begin
                if (advance)
                begin
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                if (advance)
                begin
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (advance)
                begin
                    if (cur_reg.last && has_trailer)
                    begin
                        state_next = ST_TRAIL;
                        cnt_next   = trailer_reg;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (advance)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == TRAILER_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            cur_next   = pop_entry;
            state_next = pop_entry.lead ? ST_LEAD : ST_HI;
        end
    end

    // output register
    always_comb
    begin
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next          = 1'b1;
            out_item_next.spi_word  = word_data;
            out_item_next.last_word = word_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            trailer_reg   <= TRAILER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                trailer_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cnt_reg      <= cnt_next;
        out_item_reg <= out_item_next;
    end

    a_trail_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRAIL |-> cnt_reg != '0)
        else $error("trailer state with zero count");

    a_lead_only_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEAD |-> cur_reg.lead)
        else $error("leading word outside frame start");

    a_trail_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRAIL |-> cur_reg.last)
        else $error("trailer after a byte not marked last");

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_item_reg))
        else $error("stalled output word lost");

endmodule

FILE: rtl/core/led_bit_to_spi_word_encoder.sv
// led bit to spi word encoder
// input channel: in_valid / in_stall / in_item, one colour byte per item,
//   msb first, last_byte marks the final byte of a frame
// output channel: out_valid / out_stall / out_item, one 16-bit line word per
//   item; each data bit becomes 0100 (zero) or 0110 (one), high nibble first
// config: cfg_we / cfg_data write the trailer word count (0..15, reset 9)
// per byte: two data words; a byte that opens a frame adds one zero word ahead,
//   a byte marked last adds the trailer zero words; the final word of a frame
//   carries last_word
// path: a byte passes the queue slot, the sequencer and the output register
// throughput: one word per cycle from the output register while out_stall is
//   low and bytes wait in the queue, with the leading word and the trailer words
//   in the same stream; the back sequencer emitting one word a cycle sets this
// a 2-entry queue separates byte intake from word generation
// reset: queue empty, no output pending, next byte opens a frame
// receiver stall: the output word holds, the sequencer pauses, the queue fills
//   and then in_stall rises
module led_bit_to_spi_word_encoder
    import lbse_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [TRAILER_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lbse_in_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lbse_out_t            out_item
);

    logic        push_valid;
    logic        push_full;
    lbse_entry_t push_entry;
    logic        pop_valid;
    logic        pop_stall;
    lbse_entry_t pop_entry;

    lbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_entry (push_entry)
    );

    lbse_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_entry  (pop_entry)
    );

    lbse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_stall (pop_stall),
        .pop_entry (pop_entry),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
